// ===== src/ffel_pkg.sv =====
// Shared constants, types and table function for the fog factor unit.
package ffel_pkg;

	// Register indexes of the configuration port
	localparam logic REG_FOG_END  = 1'b0;
	localparam logic REG_FOG_MODE = 1'b1;

	// Fog mode codes
	localparam logic [1:0] MODE_EXP     = 2'd0;
	localparam logic [1:0] MODE_LIN_HALF_UNIT = 2'd1;
	localparam logic [1:0] MODE_LIN_HALF_END  = 2'd2;
	localparam logic [1:0] MODE_LIN_QUART_END = 2'd3;

	// Field widths and reset values
	localparam int DIST_W = 24;
	localparam int END_W = 24;
	localparam int FACTOR_W = 17;
	localparam logic [END_W-1:0] FOG_END_RESET = 24'd256;
	localparam logic [END_W-1:0] ONE_Q8 = 24'd256;
	localparam logic [END_W-1:0] HALF_Q8 = 24'd128;
	localparam logic [FACTOR_W-1:0] ONE_Q16 = 17'd65536;

	// Quotient bits produced by the divider, one per stage
	localparam int DIV_BITS = 21;
	localparam int EXP_TABLE_DEPTH_DEF = 256;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;

	// Control flags that follow an item down the pipeline
	typedef struct packed {
		logic exp;
		logic zero;
		logic one;
	} ctl_t;

	// exp(-y) in Q1.16 with y in Q0.30, by the alternating series
	function automatic logic [FACTOR_W-1:0] pow2_frac_entry(input logic [63:0] y);
		logic [63:0] term;
		longint sum;
		term = 64'd1 << 30;
		sum = longint'(term);
		for (int k = 1; k < 40; k++) begin
			if (term != 64'd0) begin
				term = ((term * y) >> 30) / 64'(k);
				if (k % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		return FACTOR_W'((64'(sum) + 64'd8192) >> 14);
	endfunction

endpackage

// ===== src/fog_factor_exp_linear.sv =====
// Fog factor unit: distance in, Q1.16 fog factor out, one item per cycle unless the output stalls.
// Throughput is one item per cycle when the output is not stalled.
// The pipeline includes the 21-stage shift-subtract divider, one quotient bit per stage.
// The whole pipeline advances together; a stalled output holds every stage.
// Reset clears all valid bits and loads fog_end = 1.0 and fog_mode = exponential.
module fog_factor_exp_linear
	import ffel_pkg::*;
#(
	parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [23:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [23:0] distance
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [16:0] fog_factor, [23:17] zero
);

	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int DEPTH_W = $clog2(EXP_TABLE_DEPTH + 1);

	logic [END_W-1:0] fog_end_q;
	logic [1:0] fog_mode_q;
	logic adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fog_end_q <= FOG_END_RESET;
			fog_mode_q <= MODE_EXP;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FOG_END: fog_end_q <= cfg_data;
				REG_FOG_MODE: fog_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Advance every stage unless the output holds an untaken transfer
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// Stage 1: capture distance
	logic valid_s1;
	logic signed [DIST_W-1:0] dist_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dist_s1 <= s_axis_tdata;
		end
	end

	// Stage 2: clamp end, form start, range, linear numerator and 6*max(d,0)
	logic [END_W-1:0] e_c, s_c, r_c, r_diff_c;
	logic signed [25:0] nlin_c;
	logic [25:0] p6_c;
	logic [DIST_W-2:0] p_c;
	logic valid_s2, exp_s2;
	logic [END_W-1:0] e_s2, r_s2;
	logic signed [25:0] nlin_s2;
	logic [25:0] p6_s2;

	always_comb begin
		e_c = (fog_end_q < ONE_Q8) ? ONE_Q8 : fog_end_q;
		unique case (fog_mode_q)
			MODE_LIN_HALF_END: s_c = e_c >> 1;
			MODE_LIN_QUART_END: s_c = e_c >> 2;
			default: s_c = HALF_Q8;
		endcase
		r_diff_c = e_c - s_c;
		r_c = (r_diff_c < ONE_Q8) ? ONE_Q8 : r_diff_c;
		nlin_c = 26'(signed'({2'b00, e_c})) - 26'(dist_s1);
		p_c = dist_s1[DIST_W-1] ? '0 : dist_s1[DIST_W-2:0];
		p6_c = {1'b0, p_c, 2'b00} + {2'b00, p_c, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			exp_s2 <= (fog_mode_q == MODE_EXP);
			e_s2 <= e_c;
			r_s2 <= r_c;
			nlin_s2 <= nlin_c;
			p6_s2 <= p6_c;
		end
	end

	// Stage 3: range flags and divider operands
	logic [28:0] e17_c;
	ctl_t ctl_c;
	logic [28:0] num_c;
	logic [END_W-1:0] den_c;

	logic valid_sd [DIV_BITS+1];
	ctl_t ctl_sd [DIV_BITS+1];
	logic [28:0] rem_sd [DIV_BITS+1];
	logic [END_W-1:0] den_sd [DIV_BITS+1];
	logic [DIV_BITS-1:0] quo_sd [DIV_BITS+1];

	always_comb begin
		e17_c = {1'b0, e_s2, 4'b0000} + {5'b00000, e_s2};
		ctl_c.exp = exp_s2;
		if (exp_s2) begin
			ctl_c.zero = ({3'b000, p6_s2} >= e17_c);
			ctl_c.one = 1'b0;
			num_c = {3'b000, p6_s2};
			den_c = e_s2;
		end else begin
			ctl_c.zero = (nlin_s2 <= 26'sd0);
			ctl_c.one = (nlin_s2 >= 26'(signed'({2'b00, r_s2})));
			num_c = {5'b00000, nlin_s2[23:0]};
			den_c = r_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd[0] <= 1'b0;
		end else if (adv) begin
			valid_sd[0] <= valid_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_sd[0] <= ctl_c;
			rem_sd[0] <= num_c;
			den_sd[0] <= den_c;
			quo_sd[0] <= '0;
		end
	end

	// Divider: one shift-subtract step per stage against the denominator (end or range) scaled by 32
	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		logic [29:0] two_c, dsc_c, diff_c;
		logic ge_c;
		always_comb begin
			two_c = {rem_sd[k], 1'b0};
			dsc_c = {1'b0, den_sd[k], 5'b00000};
			ge_c = (two_c >= dsc_c);
			diff_c = two_c - dsc_c;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sd[k+1] <= 1'b0;
			end else if (adv) begin
				valid_sd[k+1] <= valid_sd[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_sd[k+1] <= ctl_sd[k];
				den_sd[k+1] <= den_sd[k];
				rem_sd[k+1] <= ge_c ? diff_c[28:0] : two_c[28:0];
				quo_sd[k+1] <= {quo_sd[k][DIV_BITS-2:0], ge_c};
			end
		end
	end

	// Fraction table, 2^(-i/depth) in Q1.16
	logic [FACTOR_W-1:0] rom [EXP_TABLE_DEPTH];
	for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
		localparam logic [63:0] Y = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
		assign rom[i] = pow2_frac_entry(Y);
	end

	// Stage 25: table index from the fraction
	logic [15+DEPTH_W:0] prod_c;
	logic valid_s25;
	ctl_t ctl_s25;
	logic [IDX_W-1:0] idx_s25;
	logic [4:0] sh_s25;
	logic [15:0] frac_s25;

	assign prod_c = quo_sd[DIV_BITS][15:0] * DEPTH_W'(EXP_TABLE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s25 <= 1'b0;
		end else if (adv) begin
			valid_s25 <= valid_sd[DIV_BITS];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s25 <= ctl_sd[DIV_BITS];
			idx_s25 <= prod_c[15+IDX_W:16];
			sh_s25 <= quo_sd[DIV_BITS][20:16];
			frac_s25 <= quo_sd[DIV_BITS][15:0];
		end
	end

	// Stage 26: table read
	logic valid_s26;
	ctl_t ctl_s26;
	logic [FACTOR_W-1:0] tab_s26;
	logic [4:0] sh_s26;
	logic [15:0] frac_s26;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s26 <= 1'b0;
		end else if (adv) begin
			valid_s26 <= valid_s25;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s26 <= ctl_s25;
			tab_s26 <= rom[idx_s25];
			sh_s26 <= sh_s25;
			frac_s26 <= frac_s25;
		end
	end

	// Stage 27: shift, clamp and select the factor
	logic [FACTOR_W-1:0] fac_c;
	logic valid_s27;
	logic [FACTOR_W-1:0] fac_s27;

	always_comb begin
		priority if (ctl_s26.zero) begin
			fac_c = '0;
		end else if (ctl_s26.exp) begin
			fac_c = tab_s26 >> sh_s26;
		end else if (ctl_s26.one) begin
			fac_c = ONE_Q16;
		end else begin
			fac_c = {1'b0, frac_s26};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s27 <= 1'b0;
		end else if (adv) begin
			valid_s27 <= valid_s26;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fac_s27 <= fac_c;
		end
	end

	assign m_axis_tvalid = valid_s27;
	assign m_axis_tdata = {7'b0000000, fac_s27};

endmodule
